@@ rtl/core/bud_pkg.sv @@
// types, constants and helpers shared by the buddy allocator modules
// no dependencies
package bud_pkg;

    localparam int MAX_ORDER = 10;
    localparam int UNIT_W    = MAX_ORDER;
    localparam int UNITS     = 1 << MAX_ORDER;
    localparam int NODE_W    = MAX_ORDER + 1;
    localparam int NODES     = (2 << MAX_ORDER) - 1;
    localparam int ORD_W     = 4;
    localparam int SIZE_W    = 11;
    localparam int GNT_W     = 4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SIZE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT,
        S_GRANT,
        S_FREE_RD,
        S_FREE_CHK,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_MERGE_SET,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic              wdata;
        logic [NODE_W-1:0] raddr;
    } free_req_t;

    typedef struct packed {
        logic              we;
        logic [UNIT_W-1:0] waddr;
        logic [GNT_W-1:0]  wdata;
        logic [UNIT_W-1:0] raddr;
    } gnt_req_t;

    typedef struct packed {
        logic [SIZE_W-1:0] units;
        logic [UNIT_W-1:0] start;
        logic [1:0]        status;
    } result_t;

    // heap index of the node of order o at block index k
    function automatic logic [NODE_W-1:0] node_of(logic [ORD_W-1:0] o,
                                                  logic [UNIT_W-1:0] k);
        logic [NODE_W-1:0] base;
        base = (NODE_W'(1) << (ORD_W'(MAX_ORDER) - o)) - NODE_W'(1);
        return base + NODE_W'(k);
    endfunction

endpackage

@@ rtl/core/bud_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bud_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bud_ctrl.sv @@
// sequencer for the buddy allocator: clearing pass, scan, split, merge
// depends on bud_pkg
module bud_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bud_pkg::ORD_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_cmd,
    input  logic [bud_pkg::SIZE_W-1:0]   in_size,
    input  logic [bud_pkg::UNIT_W-1:0]   in_addr,
    output logic                         res_valid,
    input  logic                         res_ready,
    output bud_pkg::result_t             res,
    output bud_pkg::free_req_t           free_req,
    input  logic                         free_rdata,
    output bud_pkg::gnt_req_t            gnt_req,
    input  logic [bud_pkg::GNT_W-1:0]    gnt_rdata
);

    bud_pkg::state_t state_reg, state_next;
    logic [bud_pkg::NODE_W-1:0] cnt_reg, cnt_next;
    logic [bud_pkg::ORD_W-1:0]  pool_reg, pool_next;
    logic                       cmd_reg, cmd_next;
    logic [bud_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [bud_pkg::UNIT_W-1:0] addr_reg, addr_next;
    logic [bud_pkg::ORD_W-1:0]  n_reg, n_next;
    logic [bud_pkg::ORD_W-1:0]  ord_reg, ord_next;
    logic [bud_pkg::UNIT_W-1:0] k_reg, k_next;
    bud_pkg::result_t           res_reg, res_next;

    logic [bud_pkg::ORD_W-1:0]  ceil_ord;
    logic [bud_pkg::UNIT_W-1:0] last_k;
    logic                       bad_size;
    logic [bud_pkg::ORD_W-1:0]  gnt_ord;

    // smallest order whose block holds the request
    always_comb
    begin
        ceil_ord = bud_pkg::ORD_W'(bud_pkg::MAX_ORDER);
        for (int i = bud_pkg::MAX_ORDER; i >= 0; i--)
        begin
            if (((bud_pkg::SIZE_W+1)'(1) << i) >= {1'b0, size_reg})
            begin
                ceil_ord = bud_pkg::ORD_W'(i);
            end
        end
    end

    assign bad_size = (size_reg == '0) ||
                      ({1'b0, size_reg} > ((bud_pkg::SIZE_W+1)'(1) << pool_reg));
    assign last_k   = bud_pkg::UNIT_W'((bud_pkg::NODE_W'(1) << (pool_reg - ord_reg))
                      - bud_pkg::NODE_W'(1));
    assign gnt_ord  = bud_pkg::ORD_W'(gnt_rdata - bud_pkg::GNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bud_pkg::S_INIT;
            cnt_reg   <= '0;
            pool_reg  <= bud_pkg::ORD_W'(bud_pkg::MAX_ORDER);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pool_reg  <= pool_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
        n_reg    <= n_next;
        ord_reg  <= ord_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bud_pkg::S_INIT:
            begin
                if (cfg_valid)
                    state_next = bud_pkg::S_INIT;
                else if (cnt_reg == bud_pkg::NODE_W'(bud_pkg::NODES - 1))
                    state_next = bud_pkg::S_IDLE;
            end
            bud_pkg::S_IDLE:
            begin
                if (cfg_valid)
                    state_next = bud_pkg::S_INIT;
                else if (in_valid)
                    state_next = (in_cmd == bud_pkg::CMD_FREE) ? bud_pkg::S_FREE_RD
                                                               : bud_pkg::S_SIZE;
            end
            bud_pkg::S_SIZE:
                state_next = bad_size ? bud_pkg::S_DONE : bud_pkg::S_SCAN_RD;
            bud_pkg::S_SCAN_RD:
                state_next = bud_pkg::S_SCAN_CHK;
            bud_pkg::S_SCAN_CHK:
            begin
                if (free_rdata)
                    state_next = bud_pkg::S_SPLIT;
                else if (k_reg == last_k && ord_reg == pool_reg)
                    state_next = bud_pkg::S_DONE;
                else
                    state_next = bud_pkg::S_SCAN_RD;
            end
            bud_pkg::S_SPLIT:
                state_next = (ord_reg > n_reg) ? bud_pkg::S_SPLIT : bud_pkg::S_GRANT;
            bud_pkg::S_GRANT:
                state_next = bud_pkg::S_DONE;
            bud_pkg::S_FREE_RD:
                state_next = bud_pkg::S_FREE_CHK;
            bud_pkg::S_FREE_CHK:
                state_next = (gnt_rdata == '0) ? bud_pkg::S_DONE : bud_pkg::S_MERGE_RD;
            bud_pkg::S_MERGE_RD:
                state_next = (ord_reg < pool_reg) ? bud_pkg::S_MERGE_CHK
                                                  : bud_pkg::S_MERGE_SET;
            bud_pkg::S_MERGE_CHK:
                state_next = free_rdata ? bud_pkg::S_MERGE_RD : bud_pkg::S_MERGE_SET;
            bud_pkg::S_MERGE_SET:
                state_next = bud_pkg::S_DONE;
            bud_pkg::S_DONE:
                state_next = res_ready ? bud_pkg::S_IDLE : bud_pkg::S_DONE;
            default:
                state_next = bud_pkg::S_INIT;
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        cnt_next  = cnt_reg;
        pool_next = pool_reg;
        cmd_next  = cmd_reg;
        size_next = size_reg;
        addr_next = addr_reg;
        n_next    = n_reg;
        ord_next  = ord_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        free_req  = '0;
        gnt_req   = '0;
        cfg_ready = 1'b0;
        in_ready  = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            bud_pkg::S_INIT:
            begin
                cfg_ready      = 1'b1;
                free_req.we    = 1'b1;
                free_req.waddr = cnt_reg;
                free_req.wdata = (cnt_reg == bud_pkg::node_of(pool_reg, '0));
                gnt_req.we     = 1'b1;
                gnt_req.waddr  = cnt_reg[bud_pkg::UNIT_W-1:0];
                cnt_next       = cnt_reg + bud_pkg::NODE_W'(1);
                if (cfg_valid)
                begin
                    pool_next = (cfg_data > bud_pkg::ORD_W'(bud_pkg::MAX_ORDER))
                              ? bud_pkg::ORD_W'(bud_pkg::MAX_ORDER) : cfg_data;
                    cnt_next  = '0;
                end
            end
            bud_pkg::S_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    pool_next = (cfg_data > bud_pkg::ORD_W'(bud_pkg::MAX_ORDER))
                              ? bud_pkg::ORD_W'(bud_pkg::MAX_ORDER) : cfg_data;
                    cnt_next  = '0;
                end
                else if (in_valid)
                begin
                    cmd_next  = in_cmd;
                    size_next = in_size;
                    addr_next = in_addr;
                end
            end
            bud_pkg::S_SIZE:
            begin
                n_next   = ceil_ord;
                ord_next = ceil_ord;
                k_next   = '0;
                res_next = '{units: '0, start: '0, status: bud_pkg::ST_BAD_SIZE};
            end
            bud_pkg::S_SCAN_RD:
                free_req.raddr = bud_pkg::node_of(ord_reg, k_reg);
            bud_pkg::S_SCAN_CHK:
            begin
                if (free_rdata)
                begin
                    free_req.we    = 1'b1;
                    free_req.waddr = bud_pkg::node_of(ord_reg, k_reg);
                end
                else if (k_reg == last_k)
                begin
                    ord_next = ord_reg + bud_pkg::ORD_W'(1);
                    k_next   = '0;
                    res_next = '{units: '0, start: '0, status: bud_pkg::ST_NO_SPACE};
                end
                else
                    k_next = k_reg + bud_pkg::UNIT_W'(1);
            end
            bud_pkg::S_SPLIT:
            begin
                if (ord_reg > n_reg)
                begin
                    // keep lower half, upper half becomes free
                    ord_next       = ord_reg - bud_pkg::ORD_W'(1);
                    k_next         = k_reg << 1;
                    free_req.we    = 1'b1;
                    free_req.waddr = bud_pkg::node_of(ord_reg - bud_pkg::ORD_W'(1),
                                                      (k_reg << 1) | bud_pkg::UNIT_W'(1));
                    free_req.wdata = 1'b1;
                end
            end
            bud_pkg::S_GRANT:
            begin
                gnt_req.we    = 1'b1;
                gnt_req.waddr = k_reg << n_reg;
                gnt_req.wdata = bud_pkg::GNT_W'(n_reg) + bud_pkg::GNT_W'(1);
                res_next      = '{units: bud_pkg::SIZE_W'(1) << n_reg,
                                  start: k_reg << n_reg, status: bud_pkg::ST_OK};
            end
            bud_pkg::S_FREE_RD:
                gnt_req.raddr = addr_reg;
            bud_pkg::S_FREE_CHK:
            begin
                res_next = '{units: '0, start: '0, status: bud_pkg::ST_BAD_ADDR};
                if (gnt_rdata != '0)
                begin
                    n_next        = gnt_ord;
                    ord_next      = gnt_ord;
                    k_next        = addr_reg >> gnt_ord;
                    gnt_req.we    = 1'b1;
                    gnt_req.waddr = addr_reg;
                end
            end
            bud_pkg::S_MERGE_RD:
                free_req.raddr = bud_pkg::node_of(ord_reg, k_reg ^ bud_pkg::UNIT_W'(1));
            bud_pkg::S_MERGE_CHK:
            begin
                if (free_rdata)
                begin
                    // buddy is free: absorb it and move one order up
                    free_req.we    = 1'b1;
                    free_req.waddr = bud_pkg::node_of(ord_reg, k_reg ^ bud_pkg::UNIT_W'(1));
                    ord_next       = ord_reg + bud_pkg::ORD_W'(1);
                    k_next         = k_reg >> 1;
                end
            end
            bud_pkg::S_MERGE_SET:
            begin
                free_req.we    = 1'b1;
                free_req.waddr = bud_pkg::node_of(ord_reg, k_reg);
                free_req.wdata = 1'b1;
                res_next       = '{units: bud_pkg::SIZE_W'(1) << n_reg,
                                   start: addr_reg, status: bud_pkg::ST_OK};
            end
            bud_pkg::S_DONE:
                res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

@@ rtl/core/buddy_allocator_top.sv @@
// buddy allocator top level: stream channels, output register, state memories
// depends on bud_pkg, bud_ram, bud_ctrl
//
// usage:
//   slave stream takes one request per beat: tuser is the command (0 allocate,
//   1 free), tdata carries request_size and free_address. master stream gives
//   one answer beat per request with status, block_start and block_units.
//   the cfg channel writes pool_order (saturated to 10) and rebuilds the pool
//   as one free block; write it only while no request is in flight.
// sequence:
//   a free reads the grant memory at free_address and answers at once for an
//   unknown address; else it merges one level per free buddy, up to the whole
//   pool, and sets the free mark of the merged block. an allocate checks the
//   size, scans the free-mark memory from the smallest fitting order upwards,
//   one node read and check at a time, then splits down level by level.
// reset and stall:
//   after reset, and after each pool_order write, a clearing pass sweeps both
//   memories; no request is taken during it. a finished answer sits in the
//   output register; if the receiver stalls, the next request is still taken
//   and waits for the register before it answers.
module buddy_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,        // pool_order
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [10:0] request_size, [20:11] free_address
    input  logic        s_axis_tuser,    // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata     // [1:0] status, [11:2] block_start, [22:12] block_units
);

    bud_pkg::free_req_t free_req;
    bud_pkg::gnt_req_t  gnt_req;
    logic               free_rdata;
    logic [bud_pkg::GNT_W-1:0] gnt_rdata;
    logic               res_valid;
    logic               res_ready;
    bud_pkg::result_t   res;
    logic               out_valid_reg, out_valid_next;
    bud_pkg::result_t   out_data_reg, out_data_next;

    bud_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_size    (s_axis_tdata[10:0]),
        .in_addr    (s_axis_tdata[20:11]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .free_req   (free_req),
        .free_rdata (free_rdata),
        .gnt_req    (gnt_req),
        .gnt_rdata  (gnt_rdata)
    );

    bud_ram #(
        .WIDTH (1),
        .DEPTH (bud_pkg::NODES)
    ) u_free_ram (
        .clk   (clk),
        .we    (free_req.we),
        .waddr (free_req.waddr),
        .wdata (free_req.wdata),
        .raddr (free_req.raddr),
        .rdata (free_rdata)
    );

    bud_ram #(
        .WIDTH (bud_pkg::GNT_W),
        .DEPTH (bud_pkg::UNITS)
    ) u_gnt_ram (
        .clk   (clk),
        .we    (gnt_req.we),
        .waddr (gnt_req.waddr),
        .wdata (gnt_req.wdata),
        .raddr (gnt_req.raddr),
        .rdata (gnt_rdata)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

endmodule
